/* rtl/core/crou_pkg.sv */
// Package for the Cholesky rank-one update core.
// Holds the action codes, state encoding, cell control struct and saturation helper.
// No dependencies.
`default_nettype none
package crou_pkg;

   localparam int IDX_W  = 4;
   localparam int VAL_W  = 32;
   localparam int COEF_W = 18;
   localparam int PROD_W = VAL_W + COEF_W;
   localparam int SUM_W  = PROD_W + 1;
   localparam int FRAC_W = 16;

   typedef enum logic [1:0] {
      ACT_WR_FACTOR = 2'd0,
      ACT_WR_VECTOR = 2'd1,
      ACT_RUN       = 2'd2,
      ACT_NONE      = 2'd3
   } action_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SQ,
      ST_RT,
      ST_RTW,
      ST_DV,
      ST_DVW,
      ST_MUL,
      ST_ROT,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic                     wr_factor;
      logic                     wr_vector;
      logic [IDX_W-1:0]         wr_row;
      logic [IDX_W-1:0]         wr_col;
      logic signed [VAL_W-1:0]  wr_data;
      logic                     load;
      logic                     mul_en;
      logic                     rot_en;
      logic                     diag_en;
      logic [IDX_W-1:0]         col;
      logic signed [COEF_W-1:0] c;
      logic signed [COEF_W-1:0] s;
      logic signed [VAL_W-1:0]  diag;
   } cell_ctl_type;

   // Q19.32 sum to Q16.16, floor, saturated
   function automatic logic signed [VAL_W-1:0] sat_q(input logic signed [SUM_W-1:0] x);
      logic signed [SUM_W-FRAC_W-1:0] sh;
      sh = x[SUM_W-1:FRAC_W];
      if (sh > (SUM_W-FRAC_W)'(signed'(33'sh0_7FFF_FFFF)))
         sat_q = 32'sh7FFF_FFFF;
      else if (sh < (SUM_W-FRAC_W)'(signed'(33'sh1_8000_0000)))
         sat_q = 32'sh8000_0000;
      else
         sat_q = sh[VAL_W-1:0];
   endfunction

endpackage
`default_nettype wire

/* rtl/core/crou_sqrt.sv */
// Bit-serial integer square root, two radicand bits per cycle.
// Depends on nothing.
`default_nettype none
module crou_sqrt (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [63:0] radicand,
   output logic             busy,
   output logic [31:0]      root
);
   logic [63:0] rad_ff, rad_in;
   logic [34:0] rem_ff, rem_in;
   logic [31:0] root_ff, root_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic [34:0] rem2;
   logic [34:0] trial;

   always_comb begin
      rem2    = {rem_ff[32:0], rad_ff[63:62]};
      trial   = {1'b0, root_ff, 2'b01};
      rad_in  = rad_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (start) begin
         rad_in  = radicand;
         rem_in  = '0;
         root_in = '0;
         cnt_in  = 6'd32;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rad_in = {rad_ff[61:0], 2'b00};
         if (rem2 >= trial) begin
            rem_in  = rem2 - trial;
            root_in = {root_ff[30:0], 1'b1};
         end else begin
            rem_in  = rem2;
            root_in = {root_ff[30:0], 1'b0};
         end
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1)
            busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign busy = busy_ff;
   assign root = root_ff;
endmodule
`default_nettype wire

/* rtl/core/crou_div.sv */
// Restoring divider, one quotient bit per cycle, 17-bit quotient.
// Caller guarantees the quotient fits; depends on nothing.
`default_nettype none
module crou_div (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [47:0] num,
   input  wire logic [31:0] den,
   output logic             busy,
   output logic [16:0]      quo
);
   logic [31:0] rem_ff, rem_in;
   logic [16:0] num_ff, num_in;
   logic [16:0] quo_ff, quo_in;
   logic [31:0] den_ff, den_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic [32:0] rem2;
   logic        ge;

   always_comb begin
      rem2    = {rem_ff, num_ff[16]};
      ge      = rem2 >= {1'b0, den_ff};
      rem_in  = rem_ff;
      num_in  = num_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (start) begin
         rem_in  = {1'b0, num[47:17]};
         num_in  = num[16:0];
         quo_in  = '0;
         den_in  = den;
         cnt_in  = 5'd17;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = ge ? 32'(rem2 - {1'b0, den_ff}) : rem2[31:0];
         quo_in = {quo_ff[15:0], ge};
         num_in = {num_ff[15:0], 1'b0};
         cnt_in = cnt_ff - 5'd1;
         if (cnt_ff == 5'd1)
            busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      num_ff <= num_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign busy = busy_ff;
   assign quo  = quo_ff;
endmodule
`default_nettype wire

/* rtl/core/crou_cell.sv */
// One row cell: stored factor row, vector entry, scratch copies and rotation datapath.
// Depends on crou_pkg.
`default_nettype none
module crou_cell #(
   parameter int DIM = 8,
   parameter int IDX = 0
) (
   input  wire logic                       clock,
   input  wire crou_pkg::cell_ctl_type     ctl,
   output logic signed [crou_pkg::VAL_W-1:0] sel_value,
   output logic signed [crou_pkg::VAL_W-1:0] vec_value
);
   import crou_pkg::*;

   localparam int CW = (DIM > 1) ? $clog2(DIM) : 1;
   localparam logic [IDX_W-1:0] ROW = IDX_W'(IDX);

   logic signed [VAL_W-1:0]  store_ff [DIM];
   logic signed [VAL_W-1:0]  work_ff  [DIM];
   logic signed [VAL_W-1:0]  vstore_ff;
   logic signed [VAL_W-1:0]  v_ff;
   logic signed [PROD_W-1:0] p_cv_ff, p_sl_ff, p_sv_ff, p_cl_ff;
   logic signed [VAL_W-1:0]  l_sel;
   logic signed [SUM_W-1:0]  v_sum, l_sum;
   logic [CW-1:0]            col_idx, wr_idx;

   assign col_idx = ctl.col[CW-1:0];
   assign wr_idx  = ctl.wr_col[CW-1:0];
   assign l_sel   = work_ff[col_idx];
   assign v_sum   = SUM_W'(p_cv_ff) - SUM_W'(p_sl_ff);
   assign l_sum   = SUM_W'(p_sv_ff) + SUM_W'(p_cl_ff);

   always_ff @(posedge clock) begin
      if (ctl.wr_factor && ctl.wr_row == ROW)
         store_ff[wr_idx] <= ctl.wr_data;
      if (ctl.wr_vector && ctl.wr_row == ROW)
         vstore_ff <= ctl.wr_data;
      if (ctl.load) begin
         work_ff <= store_ff;
         v_ff    <= vstore_ff;
      end else begin
         if (ctl.rot_en && ROW > ctl.col) begin
            v_ff             <= sat_q(v_sum);
            work_ff[col_idx] <= sat_q(l_sum);
         end
         if (ctl.diag_en && ROW == ctl.col)
            work_ff[col_idx] <= ctl.diag;
      end
      if (ctl.mul_en) begin
         p_cv_ff <= ctl.c * v_ff;
         p_sl_ff <= ctl.s * l_sel;
         p_sv_ff <= ctl.s * v_ff;
         p_cl_ff <= ctl.c * l_sel;
      end
   end

   assign sel_value = l_sel;
   assign vec_value = v_ff;
endmodule
`default_nettype wire

/* rtl/core/cholesky_rank_one_update_core.sv */
// Cholesky rank-one update core: a chain of DIM row cells, one shared square root, two dividers.
// Loads write the addressed cell directly. A run does one square root and two parallel divides
// per column (divides skipped for a zero root), then emits DIM*(DIM+1)/2 transactions, one per cycle when not stalled.
// Synchronous active-high reset clears control state; factor and vector stores are undefined
// until written. Depends on crou_pkg, crou_cell, crou_sqrt, crou_div.
`default_nettype none
module cholesky_rank_one_update_core #(
   parameter int DIM = 8
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [39:0] req_tdata,  // row_index[3:0], col_index[7:4], value[39:8]
   input  wire logic [1:0]  req_tuser,  // action[1:0]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [39:0]      rsp_tdata,  // out_row[3:0], out_col[7:4], out_value[39:8]
   output logic             rsp_tlast
);
   import crou_pkg::*;

   localparam int CW = (DIM > 1) ? $clog2(DIM) : 1;
   localparam logic [IDX_W-1:0] LAST = IDX_W'(DIM - 1);
   localparam logic [IDX_W-1:0] NROW = IDX_W'(DIM);

   state_type               state_ff, state_in;
   logic [IDX_W-1:0]        col_ff, col_in;
   logic [IDX_W-1:0]        orow_ff, orow_in, ocol_ff, ocol_in;
   logic [31:0]             al_ff, al_in, av_ff, av_in;
   logic                    sl_ff, sl_in, sv_ff, sv_in;
   logic [63:0]             sqa_ff, sqb_ff;
   logic signed [COEF_W-1:0] c_ff, c_in, s_ff, s_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [39:0]             rsp_data_ff, rsp_data_in;
   logic                    rsp_last_ff, rsp_last_in;

   cell_ctl_type            ctl;
   logic signed [VAL_W-1:0] cell_sel [DIM];
   logic signed [VAL_W-1:0] cell_vec [DIM];
   logic signed [VAL_W-1:0] lii, vi, diag_sat;

   logic        sq_start, sq_busy;
   logic [31:0] root;
   logic        dv_start, dc_busy, ds_busy;
   logic [16:0] qc, qs;

   action_type       act;
   logic [IDX_W-1:0] in_row, in_col;
   logic             accept, load_out;

   assign act    = action_type'(req_tuser);
   assign in_row = req_tdata[3:0];
   assign in_col = req_tdata[7:4];
   assign accept = req_tvalid && req_tready;
   assign req_tready = (state_ff == ST_IDLE);

   assign lii      = cell_sel[col_ff[CW-1:0]];
   assign vi       = cell_vec[col_ff[CW-1:0]];
   assign diag_sat = root[31] ? 32'sh7FFF_FFFF : signed'(root);
   assign load_out = (state_ff == ST_EMIT) && (!rsp_valid_ff || rsp_tready);

   genvar g;
   generate
      for (g = 0; g < DIM; g++) begin : g_cell
         crou_cell #(.DIM(DIM), .IDX(g)) u_cell (
            .clock     (clock),
            .ctl       (ctl),
            .sel_value (cell_sel[g]),
            .vec_value (cell_vec[g])
         );
      end
   endgenerate

   crou_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sq_start),
      .radicand (sqa_ff + sqb_ff),
      .busy     (sq_busy),
      .root     (root)
   );

   crou_div u_div_c (
      .clock (clock),
      .reset (reset),
      .start (dv_start),
      .num   ({al_ff, 16'd0}),
      .den   (root),
      .busy  (dc_busy),
      .quo   (qc)
   );

   crou_div u_div_s (
      .clock (clock),
      .reset (reset),
      .start (dv_start),
      .num   ({av_ff, 16'd0}),
      .den   (root),
      .busy  (ds_busy),
      .quo   (qs)
   );

   always_comb begin
      state_in     = state_ff;
      col_in       = col_ff;
      orow_in      = orow_ff;
      ocol_in      = ocol_ff;
      al_in        = al_ff;
      av_in        = av_ff;
      sl_in        = sl_ff;
      sv_in        = sv_ff;
      c_in         = c_ff;
      s_in         = s_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      sq_start     = 1'b0;
      dv_start     = 1'b0;

      ctl           = '0;
      ctl.wr_row    = in_row;
      ctl.wr_col    = in_col;
      ctl.wr_data   = signed'(req_tdata[39:8]);
      ctl.col       = (state_ff == ST_EMIT) ? ocol_ff : col_ff;
      ctl.c         = c_ff;
      ctl.s         = s_ff;
      ctl.diag      = diag_sat;

      if (rsp_valid_ff && rsp_tready)
         rsp_valid_in = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (act)
                  ACT_WR_FACTOR: ctl.wr_factor = (in_row < NROW) && (in_col <= in_row);
                  ACT_WR_VECTOR: ctl.wr_vector = (in_row < NROW);
                  ACT_RUN: begin
                     ctl.load = 1'b1;
                     col_in   = '0;
                     state_in = ST_SQ;
                  end
                  default: ;
               endcase
            end
         end
         ST_SQ: begin
            sl_in    = lii[31];
            sv_in    = vi[31];
            al_in    = lii[31] ? 32'(-lii) : 32'(lii);
            av_in    = vi[31] ? 32'(-vi) : 32'(vi);
            state_in = ST_RT;
         end
         ST_RT: begin
            sq_start = 1'b1;
            state_in = ST_RTW;
         end
         ST_RTW: begin
            if (!sq_busy)
               state_in = ST_DV;
         end
         ST_DV: begin
            if (root == '0) begin
               c_in     = COEF_W'(65536);
               s_in     = '0;
               state_in = ST_MUL;
            end else begin
               dv_start = 1'b1;
               state_in = ST_DVW;
            end
         end
         ST_DVW: begin
            if (!dc_busy && !ds_busy) begin
               c_in     = sl_ff ? -signed'({1'b0, qc}) : signed'({1'b0, qc});
               s_in     = sv_ff ? -signed'({1'b0, qs}) : signed'({1'b0, qs});
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            ctl.mul_en = 1'b1;
            state_in   = ST_ROT;
         end
         ST_ROT: begin
            ctl.rot_en  = 1'b1;
            ctl.diag_en = 1'b1;
            if (col_ff == LAST) begin
               orow_in  = '0;
               ocol_in  = '0;
               state_in = ST_EMIT;
            end else begin
               col_in   = col_ff + IDX_W'(1);
               state_in = ST_SQ;
            end
         end
         ST_EMIT: begin
            if (load_out) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {cell_sel[orow_ff[CW-1:0]], ocol_ff, orow_ff};
               rsp_last_in  = (orow_ff == LAST) && (ocol_ff == LAST);
               if (ocol_ff == orow_ff) begin
                  ocol_in = '0;
                  orow_in = orow_ff + IDX_W'(1);
                  if (orow_ff == LAST)
                     state_in = ST_IDLE;
               end else begin
                  ocol_in = ocol_ff + IDX_W'(1);
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         col_ff       <= '0;
         orow_ff      <= '0;
         ocol_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         col_ff       <= col_in;
         orow_ff      <= orow_in;
         ocol_ff      <= ocol_in;
      end
      al_ff       <= al_in;
      av_ff       <= av_in;
      sl_ff       <= sl_in;
      sv_ff       <= sv_in;
      sqa_ff      <= al_in * al_in;
      sqb_ff      <= av_in * av_in;
      c_ff        <= c_in;
      s_ff        <= s_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   a_div_nonzero: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DVW |-> root != '0)
      else $error("divide with zero radius");

   a_emit_lower: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_EMIT |-> orow_ff <= LAST && ocol_ff <= orow_ff)
      else $error("readout index outside lower triangle");

   a_col_walk: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_ROT && col_ff != LAST |=> state_ff == ST_SQ)
      else $error("column walk ended early");

   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      load_out && rsp_last_in |=> state_ff == ST_IDLE && rsp_tvalid)
      else $error("last transaction without return to idle");
endmodule
`default_nettype wire

/* tb/tb_top.sv */
// Testbench for cholesky_rank_one_update_core: loads factor and vector entries, runs
// rank-one updates and checks every emitted entry against a fixed-point predictor.
// Depends on crou_pkg and the core RTL.
`default_nettype none
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import crou_pkg::*;

   localparam int DIM        = 8;
   localparam int NUM_ITEMS  = 380;
   localparam int QUIET_FROM = 330;
   localparam longint CYCLE_LIMIT = 2000000;

   typedef struct {
      logic [3:0]  row;
      logic [3:0]  col;
      logic [31:0] value;
      logic        last;
   } entry_type;

   typedef struct {
      action_type  act;
      logic [3:0]  row;
      logic [3:0]  col;
      logic [31:0] value;
   } stim_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata = '0;  // row_index[3:0], col_index[7:4], value[39:8]
   logic [1:0]  req_tuser = ACT_NONE;  // action[1:0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;  // out_row[3:0], out_col[7:4], out_value[39:8]
   logic        rsp_tlast;

   cholesky_rank_one_update_core #(.DIM(DIM)) u_top (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tlast(rsp_tlast)
   );

   always #5 clock = ~clock;

   longint    factor_mem [DIM][DIM];
   longint    upd_vec [DIM];
   entry_type pending_entries [$];
   int        errors = 0;
   int        items_sent = 0;
   int        runs_sent = 0;
   int        entries_seen = 0;
   longint    cycles = 0;
   bit        quiet = 1'b0;
   int        long_hold = 0;

   function automatic longint unsigned int_sqrt(longint unsigned x);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > x) bitv >>= 2;
      while (bitv != 0) begin
         if (x >= res + bitv) begin
            x -= res + bitv;
            res = (res >> 1) + bitv;
         end else begin
            res >>= 1;
         end
         bitv >>= 2;
      end
      return res;
   endfunction

   function automatic longint sat_word(longint x);
      if (x > 64'sd2147483647) return 64'sd2147483647;
      if (x < -64'sd2147483648) return -64'sd2147483648;
      return x;
   endfunction

   // Givens sweep over scratch copies, then queue every lower entry row by row
   function automatic void rotate_and_queue();
      longint a [DIM][DIM];
      longint v [DIM];
      longint lii, vi, r, c, s, vp, lp;
      longint unsigned al, av;
      entry_type e;
      a = factor_mem;
      v = upd_vec;
      for (int i = 0; i < DIM; i++) begin
         lii = a[i][i];
         vi = v[i];
         al = (lii < 0) ? -lii : lii;
         av = (vi < 0) ? -vi : vi;
         r = longint'(int_sqrt(al * al + av * av));
         if (r == 0) begin
            c = 65536;
            s = 0;
         end else begin
            c = (lii * 65536) / r;
            s = (vi * 65536) / r;
         end
         a[i][i] = sat_word(r);
         for (int j = i + 1; j < DIM; j++) begin
            vp = v[j];
            lp = a[j][i];
            v[j] = sat_word((c * vp - s * lp) >>> 16);
            a[j][i] = sat_word((s * vp + c * lp) >>> 16);
         end
      end
      for (int i = 0; i < DIM; i++)
         for (int j = 0; j <= i; j++) begin
            e.row = 4'(i);
            e.col = 4'(j);
            e.value = a[i][j][31:0];
            e.last = (i == DIM - 1 && j == DIM - 1);
            pending_entries.push_back(e);
         end
   endfunction

   function automatic void predict(stim_type t);
      case (t.act)
         ACT_WR_FACTOR: if (t.row < DIM && t.col <= t.row)
            factor_mem[t.row][t.col] = longint'($signed(t.value));
         ACT_WR_VECTOR: if (t.row < DIM)
            upd_vec[t.row] = longint'($signed(t.value));
         ACT_RUN: rotate_and_queue();
         default: ;
      endcase
   endfunction

   function automatic logic [31:0] rand_value();
      case ($urandom_range(0, 9))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2, 3: return $urandom;
         default: return $urandom_range(0, 32'h000F_FFFF) - 32'h0008_0000;
      endcase
   endfunction

   task automatic send(stim_type t);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_tvalid = 1'b0;
         repeat ($urandom_range(1, 8)) @(negedge clock);
      end
      req_tuser = t.act;
      req_tdata = {t.value, t.col, t.row};
      req_tvalid = 1'b1;
      do @(posedge clock); while (!req_tready);
      predict(t);
      items_sent++;
      if (t.act == ACT_RUN) runs_sent++;
      @(negedge clock);
   endtask

   task automatic fill_all(bit zero);
      for (int i = 0; i < DIM; i++) begin
         for (int j = 0; j <= i; j++)
            send('{ACT_WR_FACTOR, 4'(i), 4'(j), zero ? 32'd0 : rand_value()});
         send('{ACT_WR_VECTOR, 4'(i), 4'($urandom), zero ? 32'd0 : rand_value()});
      end
   endtask

   stim_type directed [] = '{
      '{ACT_RUN,       4'd0,  4'd0,  32'h0000_0000},
      '{ACT_WR_FACTOR, 4'd0,  4'd0,  32'h7FFF_FFFF},
      '{ACT_WR_VECTOR, 4'd0,  4'd15, 32'h8000_0000},
      '{ACT_WR_FACTOR, 4'd7,  4'd7,  32'hFFFF_FFFF},
      '{ACT_WR_VECTOR, 4'd7,  4'd0,  32'h7FFF_FFFF},
      '{ACT_WR_FACTOR, 4'd3,  4'd5,  32'h1234_5678},
      '{ACT_WR_FACTOR, 4'd8,  4'd0,  32'h0001_0000},
      '{ACT_WR_FACTOR, 4'd15, 4'd15, 32'hA5A5_5A5A},
      '{ACT_WR_VECTOR, 4'd9,  4'd0,  32'h5A5A_A5A5},
      '{ACT_WR_VECTOR, 4'd15, 4'd0,  32'hFFFF_FFFF},
      '{ACT_NONE,      4'd2,  4'd1,  32'h0001_0000},
      '{ACT_RUN,       4'd0,  4'd0,  32'h0000_0000},
      '{ACT_WR_FACTOR, 4'd1,  4'd0,  32'h8000_0000},
      '{ACT_WR_FACTOR, 4'd1,  4'd1,  32'h0000_0000},
      '{ACT_WR_VECTOR, 4'd1,  4'd0,  32'h0000_0000},
      '{ACT_RUN,       4'd15, 4'd15, 32'hFFFF_FFFF},
      '{ACT_WR_FACTOR, 4'd4,  4'd2,  32'h0002_8000},
      '{ACT_WR_VECTOR, 4'd4,  4'd0,  32'hFFFE_0000},
      '{ACT_RUN,       4'd0,  4'd0,  32'h0000_0000}
   };

   // receiver ready: random bursts of back-pressure, one long hold on request
   initial begin
      int hold;
      hold = 0;
      forever begin
         @(negedge clock);
         if (long_hold > 0) begin
            rsp_tready = 1'b0;
            long_hold--;
         end else if (hold > 0) begin
            rsp_tready = 1'b0;
            hold--;
         end else if (!quiet && $urandom_range(0, 5) == 0) begin
            rsp_tready = 1'b0;
            hold = $urandom_range(0, 7);
         end else begin
            rsp_tready = !reset;
         end
      end
   end

   always @(posedge clock) begin
      entry_type e;
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("FAILED: results differ");
         $finish;
      end
      if (!reset && rsp_tvalid && rsp_tready) begin
         entries_seen++;
         if (pending_entries.size() == 0) begin
            $error("unexpected transaction row=%0d col=%0d", rsp_tdata[3:0], rsp_tdata[7:4]);
            errors++;
         end else begin
            e = pending_entries.pop_front();
            if (rsp_tdata[3:0] !== e.row) begin
               $error("out_row: expected %0d, got %0d", e.row, rsp_tdata[3:0]);
               errors++;
            end
            if (rsp_tdata[7:4] !== e.col) begin
               $error("out_col: expected %0d, got %0d", e.col, rsp_tdata[7:4]);
               errors++;
            end
            if (rsp_tdata[39:8] !== e.value) begin
               $error("out_value (%0d,%0d): expected %h, got %h", e.row, e.col,
                      e.value, rsp_tdata[39:8]);
               errors++;
            end
            if (rsp_tlast !== e.last) begin
               $error("last: expected %0b, got %0b", e.last, rsp_tlast);
               errors++;
            end
         end
      end
   end

   initial begin
      int n, seq;
      for (int i = 0; i < DIM; i++) begin
         upd_vec[i] = 0;
         for (int j = 0; j < DIM; j++) factor_mem[i][j] = 0;
      end
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      fill_all(1'b1);
      foreach (directed[k]) send(directed[k]);
      fill_all(1'b0);

      seq = 0;
      while (items_sent < NUM_ITEMS) begin
         if (items_sent > QUIET_FROM) quiet = 1'b1;
         n = $urandom_range(1, 12);
         for (int k = 0; k < n; k++) begin
            if ($urandom_range(0, 9) == 0)
               send('{action_type'($urandom_range(0, 3) == 0 ? ACT_NONE : $urandom_range(0, 1)),
                      4'($urandom), 4'($urandom), $urandom});
            else if ($urandom_range(0, 2) == 0)
               send('{ACT_WR_VECTOR, 4'($urandom_range(0, DIM - 1)), 4'($urandom),
                      rand_value()});
            else begin
               int r;
               r = $urandom_range(0, DIM - 1);
               send('{ACT_WR_FACTOR, 4'(r), 4'($urandom_range(0, r)), rand_value()});
            end
         end
         send('{ACT_RUN, 4'($urandom), 4'($urandom), $urandom});
         seq++;
         if (seq == 4) long_hold = 900;
      end
      req_tvalid = 1'b0;

      while (pending_entries.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (pending_entries.size() != 0) errors++;
      $display("Covered %0d input transactions, %0d update runs, %0d entries checked.",
               items_sent, runs_sent, entries_seen);
      if (errors == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end
endmodule
`default_nettype wire
